// ===== hdl/srpd_pkg.sv =====
// Package for the spectral phase ramp delay core: widths, codes, types,
// the arctangent table and the saturation helper. No dependencies.
package srpd_pkg;

  localparam int SAMPLE_W = 24;
  localparam int BIN_W    = 15;
  localparam int STEP_W   = 32;
  localparam int SIZE_W   = 5;
  localparam int MAX_LOG2 = 16;
  localparam int MULT_W   = MAX_LOG2;
  localparam int QW       = SAMPLE_W + 1;
  localparam int GUARD    = 16;
  localparam int KINV_W   = 31;
  localparam int PROD_W   = QW + KINV_W;
  localparam int XW       = 42;
  localparam int ZW       = 33;
  localparam int STEPS    = 30;
  localparam int IDX_W    = 5;
  localparam int RND_W    = XW - GUARD;

  localparam logic signed [KINV_W-1:0] KINV = 31'sd652032874;

  localparam logic [1:0] CFG_PHASE_STEP = 2'd0;
  localparam logic [1:0] CFG_SIZE_LOG2  = 2'd1;
  localparam logic [1:0] CFG_GEN_MODE   = 2'd2;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic [BIN_W-1:0]       bin;
    logic                   bin0;
    logic signed [QW-1:0]   dc;
    logic                   exact;
  } side_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  function automatic logic [31:0] atan_lut(input logic [IDX_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Clamp a rounded value to the signed sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] hi;
    logic signed [RND_W-1:0] lo;
    hi = RND_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    lo = -RND_W'(64'sd1 <<< (SAMPLE_W - 1));
    if (v > hi) return hi[SAMPLE_W-1:0];
    if (v < lo) return lo[SAMPLE_W-1:0];
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

// ===== hdl/srpd_front.sv =====
// Front end: phase multiply, quadrant fold with 1/K prescale multiply,
// and prescale rounding. Three register stages. Uses srpd_pkg.
module srpd_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic                              in_valid,
  input  logic [srpd_pkg::BIN_W-1:0]        bin_index,
  input  logic signed [srpd_pkg::SAMPLE_W-1:0] in_real,
  input  logic signed [srpd_pkg::SAMPLE_W-1:0] in_imag,
  input  logic [srpd_pkg::STEP_W-1:0]       phase_step,
  input  logic [srpd_pkg::SIZE_W-1:0]       size_log2,
  input  logic                              generate_mode,
  output logic                              out_valid,
  output srpd_pkg::side_t                   out_side,
  output srpd_pkg::vec_t                    out_vec
);
  import srpd_pkg::*;

  // stage A
  logic                   a_valid;
  side_t                  a_side;
  logic signed [QW-1:0]   a_x, a_y;
  logic [31:0]            a_angle;
  // stage B
  logic                   b_valid;
  side_t                  b_side;
  logic signed [QW-1:0]   b_qx, b_qy;
  logic signed [PROD_W-1:0] b_px, b_py;
  logic [29:0]            b_z;

  logic [SIZE_W-1:0]      l_clamp;
  logic [MULT_W-1:0]      half, mult;
  logic signed [QW-1:0]   one, src_re, src_im;
  logic                   is_bin0;
  logic signed [QW-1:0]   qx, qy;
  logic signed [PROD_W-1:0] rx, ry;
  logic signed [XW-1:0]   ex, ey;

  always_comb begin
    one     = QW'(1) <<< (SAMPLE_W - 1);
    is_bin0 = (bin_index == '0);
    l_clamp = (size_log2 > SIZE_W'(MAX_LOG2)) ? SIZE_W'(MAX_LOG2) : size_log2;
    half    = (l_clamp == '0) ? '0 : (MULT_W'(1) << (l_clamp - SIZE_W'(1)));
    mult    = is_bin0 ? half : MULT_W'(bin_index);
    src_re  = generate_mode ? one : QW'(in_real);
    src_im  = generate_mode ? one : QW'(in_imag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= in_valid;
    end
    if (advance) begin
      a_side.bin   <= bin_index;
      a_side.bin0  <= is_bin0;
      a_side.dc    <= src_re;
      a_side.exact <= 1'b0;
      // bin zero rotates (Nyquist + 0j); the unit phasor has no imaginary part
      a_x          <= is_bin0 ? src_im : src_re;
      a_y          <= (is_bin0 || generate_mode) ? '0 : src_im;
      a_angle      <= 32'(mult * phase_step);
    end
  end

  // quarter-turn rotation by swaps and negations
  always_comb begin
    case (a_angle[31:30])
      QUAD_1: begin qx = -a_y; qy = a_x;  end
      QUAD_2: begin qx = -a_x; qy = -a_y; end
      QUAD_3: begin qx = a_y;  qy = -a_x; end
      default: begin qx = a_x; qy = a_y; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= a_valid;
    end
    if (advance) begin
      b_side       <= a_side;
      b_side.exact <= (a_angle[29:0] == '0);
      b_qx         <= qx;
      b_qy         <= qy;
      b_px         <= PROD_W'(qx) * PROD_W'(KINV);
      b_py         <= PROD_W'(qy) * PROD_W'(KINV);
      b_z          <= a_angle[29:0];
    end
  end

  always_comb begin
    rx = b_px + (PROD_W'(1) <<< (30 - GUARD - 1));
    ry = b_py + (PROD_W'(1) <<< (30 - GUARD - 1));
    ex = XW'(b_qx) <<< GUARD;
    ey = XW'(b_qy) <<< GUARD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= b_valid;
    end
    if (advance) begin
      out_side  <= b_side;
      out_vec.x <= b_side.exact ? ex : XW'(rx >>> (30 - GUARD));
      out_vec.y <= b_side.exact ? ey : XW'(ry >>> (30 - GUARD));
      out_vec.z <= ZW'(b_z);
    end
  end

endmodule

// ===== hdl/srpd_cordic_stage.sv =====
// One registered CORDIC rotation step; exact angles pass through.
// Uses srpd_pkg for the vector types and arctangent table.
module srpd_cordic_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [srpd_pkg::IDX_W-1:0]  step,
  input  logic                        in_valid,
  input  srpd_pkg::side_t             in_side,
  input  srpd_pkg::vec_t              in_vec,
  output logic                        out_valid,
  output srpd_pkg::side_t             out_side,
  output srpd_pkg::vec_t              out_vec
);
  import srpd_pkg::*;

  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] da;
  vec_t                 nxt;

  always_comb begin
    dx  = in_vec.y >>> step;
    dy  = in_vec.x >>> step;
    da  = ZW'(atan_lut(step));
    nxt = in_vec;
    if (!in_side.exact) begin
      if (!in_vec.z[ZW-1]) begin
        nxt.x = in_vec.x - dx;
        nxt.y = in_vec.y + dy;
        nxt.z = in_vec.z - da;
      end else begin
        nxt.x = in_vec.x + dx;
        nxt.y = in_vec.y - dy;
        nxt.z = in_vec.z + da;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      out_side <= in_side;
      out_vec  <= nxt;
    end
  end

endmodule

// ===== hdl/srpd_back.sv =====
// Output stage: round out of guard bits, saturate, place bin-zero fields.
// Uses srpd_pkg.
module srpd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic                              in_valid,
  input  srpd_pkg::side_t                   in_side,
  input  srpd_pkg::vec_t                    in_vec,
  output logic                              out_valid,
  output logic [srpd_pkg::BIN_W-1:0]        bin_number,
  output logic signed [srpd_pkg::SAMPLE_W-1:0] out_real,
  output logic signed [srpd_pkg::SAMPLE_W-1:0] out_imag
);
  import srpd_pkg::*;

  logic signed [XW-1:0]    tx, ty;
  logic signed [RND_W-1:0] rx, ry;
  logic signed [SAMPLE_W-1:0] sx, sy, sdc;

  always_comb begin
    tx  = in_vec.x + (XW'(1) <<< (GUARD - 1));
    ty  = in_vec.y + (XW'(1) <<< (GUARD - 1));
    rx  = tx[XW-1:GUARD];
    ry  = ty[XW-1:GUARD];
    sx  = sat_sample(rx);
    sy  = sat_sample(ry);
    sdc = sat_sample(RND_W'(in_side.dc));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      bin_number <= in_side.bin;
      out_real   <= in_side.bin0 ? sdc : sx;
      out_imag   <= in_side.bin0 ? sx : sy;
    end
  end

endmodule

// ===== hdl/spectral_phase_ramp_delay.sv =====
// Top level of the spectral phase ramp delay core: config registers,
// pipeline assembly and checks. Uses srpd_pkg, srpd_front,
// srpd_cordic_stage and srpd_back.
//
//   channel | handshake                | payload
//   --------+--------------------------+-----------------------------------
//   in      | in_valid / in_ready      | bin_index, in_real, in_imag
//   out     | out_valid / out_ready    | bin_number, out_real, out_imag
//   cfg     | cfg_we (no wait)         | cfg_index, cfg_data
//
// One transaction enters per cycle while in_ready is high. The pipe has 3 front
// stages for phase multiply, quadrant/prescale multiply and rounding, 30 CORDIC
// stages and 1 output stage. The 30-step rotation chain sets the latency.
// Reset clears all valid bits and loads phase_step 0, size_log2 10, apply mode.
// A stall at the output freezes every stage at once; in_ready drops only
// while a finished result sits unclaimed in the output register.
module spectral_phase_ramp_delay_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [srpd_pkg::BIN_W-1:0]           bin_index,
  input  logic signed [srpd_pkg::SAMPLE_W-1:0] in_real,
  input  logic signed [srpd_pkg::SAMPLE_W-1:0] in_imag,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [srpd_pkg::BIN_W-1:0]           bin_number,
  output logic signed [srpd_pkg::SAMPLE_W-1:0] out_real,
  output logic signed [srpd_pkg::SAMPLE_W-1:0] out_imag,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [srpd_pkg::STEP_W-1:0]          cfg_data
);
  import srpd_pkg::*;

  logic [STEP_W-1:0] phase_step;
  logic [SIZE_W-1:0] size_log2;
  logic              generate_mode;
  logic              advance;

  logic  cv [STEPS+1];
  side_t cs [STEPS+1];
  vec_t  cvec [STEPS+1];

  // Config writes land directly; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= '0;
      size_log2     <= SIZE_W'(10);
      generate_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_STEP: phase_step    <= cfg_data;
        CFG_SIZE_LOG2:  size_log2     <= cfg_data[SIZE_W-1:0];
        CFG_GEN_MODE:   generate_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipe unless the output holds an unclaimed result.
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  srpd_front u_front (
    .clk, .rst, .advance,
    .in_valid, .bin_index, .in_real, .in_imag,
    .phase_step, .size_log2, .generate_mode,
    .out_valid (cv[0]),
    .out_side  (cs[0]),
    .out_vec   (cvec[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    srpd_cordic_stage u_stage (
      .clk, .rst, .advance,
      .step      (IDX_W'(i)),
      .in_valid  (cv[i]),
      .in_side   (cs[i]),
      .in_vec    (cvec[i]),
      .out_valid (cv[i+1]),
      .out_side  (cs[i+1]),
      .out_vec   (cvec[i+1])
    );
  end

  srpd_back u_back (
    .clk, .rst, .advance,
    .in_valid (cv[STEPS]),
    .in_side  (cs[STEPS]),
    .in_vec   (cvec[STEPS]),
    .out_valid, .bin_number, .out_real, .out_imag
  );

  // A stall must hold the valid bits at both ends of the CORDIC chain.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(cv[STEPS]) && $stable(cv[0]))
    else $error("pipeline moved during stall");

  // Generate mode at bin zero always gives a full-scale DC term.
  a_gen_dc: assert property (@(posedge clk) disable iff (rst)
    out_valid && bin_number == '0 && generate_mode |->
      out_real == {1'b0, {(SAMPLE_W-1){1'b1}}})
    else $error("generate-mode DC not full scale");

  // Nothing is presented in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !cv[0])
    else $error("valid set after reset");

endmodule
